// ===== hw/rtl/srmim_pkg.sv =====
// Package for the sparse row merge intersect multiply block.
// Holds the input operation codes, the internal command type and queue sizing.
// No dependencies.
`default_nettype none

package srmim_pkg;

  // Operation codes on the input channel
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PROBE = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam int unsigned COL_W = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned PROD_W = 64;

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = 2;
  localparam int unsigned CMDQ_CW    = 3;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_PROBE,
    CMD_END
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [COL_W-1:0]  col;
    logic [VAL_W-1:0]  val;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sparse_row_merge_intersect_multiply.sv =====
// Top level of the sparse row element-wise multiply by merge intersection.
// Instantiates srmim_front, srmim_cmdq and srmim_back; uses srmim_pkg.
//
// Usage:
//   Input channel is a queue write side: an item is taken at a clock edge
//   with push high and full low. operation 0 loads an A element of the row
//   into the row buffer, 1 probes with a B element, 2 ends the row. Items
//   with operation 3 or a load/probe column of COLS or more are taken and dropped.
//   Result channel is a queue read side: while empty is low the oldest
//   result sits on the result ports; it is taken at an edge with pop high.
//   A probe matching an A column at or past the pointer gives column and the
//   64-bit signed product; an end-of-row item gives a marker with row_end
//   set, row_overflow reporting dropped A elements, and clears the buffer.
// Timing: a four-entry command queue decouples input from execution. The
//   back end takes a load or end item in its idle state; a probe goes on to
//   a read state that skips A entries one read at a time. An end marker is
//   registered as its item leaves the queue, a probe match in the read state.
// Reset clears queue, buffer fill, pointer and overflow flag; no clearing
//   pass is needed. A stalled receiver holds the result; the back end then
//   waits at its next probe or end item and the queue fills until full rises.
`default_nettype none

module sparse_row_merge_intersect_multiply #(
  parameter int unsigned     ROW_NNZ_MAX = 256,
  parameter longint unsigned COLS        = 64'd65536
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [1:0]                     operation_i,
  input  wire logic [srmim_pkg::COL_W-1:0]    element_column_i,
  input  wire logic signed [srmim_pkg::VAL_W-1:0] element_value_i,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [srmim_pkg::COL_W-1:0]         result_column_o,
  output logic signed [srmim_pkg::PROD_W-1:0] product_o,
  output logic                                row_end_o,
  output logic                                row_overflow_o
);

  logic            q_full;
  logic            q_push;
  srmim_pkg::cmd_t q_in;
  logic            q_valid;
  logic            q_pop;
  srmim_pkg::cmd_t q_out;

  // Queue full stalls the input side
  assign full = q_full;

  srmim_front #(
    .COLS (COLS)
  ) u_front (
    .push             (push),
    .operation_i      (operation_i),
    .element_column_i (element_column_i),
    .element_value_i  (element_value_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_cmd_o          (q_in)
  );

  srmim_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_out)
  );

  srmim_back #(
    .ROW_NNZ_MAX (ROW_NNZ_MAX)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_out),
    .cmd_pop_o       (q_pop),
    .pop             (pop),
    .empty           (empty),
    .result_column_o (result_column_o),
    .product_o       (product_o),
    .row_end_o       (row_end_o),
    .row_overflow_o  (row_overflow_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/srmim_front.sv =====
// Front end of the sparse row merge intersect multiply block.
// Classifies input items into commands and drops the ones with no effect.
// Depends on srmim_pkg.
`default_nettype none

module srmim_front #(
  parameter longint unsigned COLS = 64'd65536
) (
  input  wire logic                      push,
  input  wire logic [1:0]                operation_i,
  input  wire logic [srmim_pkg::COL_W-1:0] element_column_i,
  input  wire logic [srmim_pkg::VAL_W-1:0] element_value_i,
  input  wire logic                      q_full_i,
  output logic                           q_push_o,
  output srmim_pkg::cmd_t                q_cmd_o
);

  logic col_ok;
  logic keep;

  assign col_ok = (64'(element_column_i) < COLS);

  // Map operation to command; unused code and out-of-range load/probe columns are dropped
  always_comb begin
    q_cmd_o.col = element_column_i;
    q_cmd_o.val = element_value_i;
    q_cmd_o.op  = srmim_pkg::CMD_END;
    keep        = 1'b0;
    case (operation_i)
      srmim_pkg::OP_LOAD: begin
        q_cmd_o.op = srmim_pkg::CMD_LOAD;
        keep       = col_ok;
      end
      srmim_pkg::OP_PROBE: begin
        q_cmd_o.op = srmim_pkg::CMD_PROBE;
        keep       = col_ok;
      end
      srmim_pkg::OP_END: begin
        q_cmd_o.op = srmim_pkg::CMD_END;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push_o = push && !q_full_i && keep;

endmodule

`default_nettype wire

// ===== hw/rtl/srmim_cmdq.sv =====
// Short command queue between front and back of the merge block.
// Plain circular buffer of cmd_t entries.
// Depends on srmim_pkg.
`default_nettype none

module srmim_cmdq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire srmim_pkg::cmd_t cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output srmim_pkg::cmd_t      cmd_o
);

  srmim_pkg::cmd_t                   mem [srmim_pkg::CMDQ_DEPTH];
  logic [srmim_pkg::CMDQ_AW-1:0]     wr_q, wr_d;
  logic [srmim_pkg::CMDQ_AW-1:0]     rd_q, rd_d;
  logic [srmim_pkg::CMDQ_CW-1:0]     cnt_q, cnt_d;
  logic                              do_push;
  logic                              do_pop;

  assign full_o  = (cnt_q == srmim_pkg::CMDQ_CW'(srmim_pkg::CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= srmim_pkg::CMDQ_CW'(srmim_pkg::CMDQ_DEPTH))
    else $error("command queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (cnt_q == srmim_pkg::CMDQ_CW'(srmim_pkg::CMDQ_DEPTH)) || (wr_q != rd_q))
    else $error("command queue pointers disagree with count");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("command queue lost a push");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/srmim_back.sv =====
// Back end of the merge block: row buffer, merge pointer, multiplier and
// result register. Carries out load, probe and end-of-row commands.
// Depends on srmim_pkg.
`default_nettype none

module srmim_back #(
  parameter int unsigned ROW_NNZ_MAX = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  input  wire srmim_pkg::cmd_t              cmd_i,
  output logic                              cmd_pop_o,
  input  wire logic                         pop,
  output logic                              empty,
  output logic [srmim_pkg::COL_W-1:0]       result_column_o,
  output logic signed [srmim_pkg::PROD_W-1:0] product_o,
  output logic                              row_end_o,
  output logic                              row_overflow_o
);

  localparam int unsigned AW = (ROW_NNZ_MAX > 1) ? $clog2(ROW_NNZ_MAX) : 1;
  localparam int unsigned CW = $clog2(ROW_NNZ_MAX + 1);
  localparam int unsigned EW = srmim_pkg::COL_W + srmim_pkg::VAL_W;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e                              state_q, state_d;
  logic [CW-1:0]                       cnt_q, cnt_d;
  logic [CW-1:0]                       ptr_q, ptr_d;
  logic [CW-1:0]                       ptr_inc;
  logic                                ovf_q, ovf_d;
  logic [srmim_pkg::COL_W-1:0]         pcol_q, pcol_d;
  logic [srmim_pkg::VAL_W-1:0]         pval_q, pval_d;
  logic                                out_valid_q, out_valid_d;
  logic [srmim_pkg::COL_W-1:0]         col_q, col_d;
  logic signed [srmim_pkg::PROD_W-1:0] prod_q, prod_d;
  logic                                end_q, end_d;
  logic                                rovf_q, rovf_d;

  logic [EW-1:0]                       mem [ROW_NNZ_MAX];
  logic [EW-1:0]                       rd_q;
  logic                                mem_we;
  logic                                mem_re;
  logic [AW-1:0]                       rd_addr;
  logic [srmim_pkg::COL_W-1:0]         rd_col;
  logic signed [srmim_pkg::VAL_W-1:0]  rd_val;
  logic signed [srmim_pkg::VAL_W-1:0]  b_val;
  logic signed [srmim_pkg::PROD_W-1:0] mul;
  logic                                slot_free;

  assign rd_col  = rd_q[EW-1 -: srmim_pkg::COL_W];
  assign rd_val  = $signed(rd_q[srmim_pkg::VAL_W-1:0]);
  assign b_val   = $signed(pval_q);
  assign mul     = rd_val * b_val;
  assign ptr_inc = ptr_q + 1'b1;

  // Result slot frees up when it is empty or taken this cycle
  assign slot_free = !out_valid_q || pop;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    ovf_d       = ovf_q;
    pcol_d      = pcol_q;
    pval_d      = pval_q;
    out_valid_d = out_valid_q && !pop;
    col_d       = col_q;
    prod_d      = prod_q;
    end_d       = end_q;
    rovf_d      = rovf_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    rd_addr     = ptr_q[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            srmim_pkg::CMD_LOAD: begin
              cmd_pop_o = 1'b1;
              if (cnt_q < CW'(ROW_NNZ_MAX)) begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            srmim_pkg::CMD_PROBE: begin
              if (slot_free) begin
                cmd_pop_o = 1'b1;
                pcol_d    = cmd_i.col;
                pval_d    = cmd_i.val;
                if (ptr_q < cnt_q) begin
                  mem_re  = 1'b1;
                  state_d = ST_READ;
                end
              end
            end
            srmim_pkg::CMD_END: begin
              if (slot_free) begin
                cmd_pop_o   = 1'b1;
                out_valid_d = 1'b1;
                col_d       = '0;
                prod_d      = '0;
                end_d       = 1'b1;
                rovf_d      = ovf_q;
                cnt_d       = '0;
                ptr_d       = '0;
                ovf_d       = 1'b0;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (rd_col < pcol_q) begin
          // Skip the smaller A column, fetch the next one if any
          ptr_d = ptr_inc;
          if (ptr_inc < cnt_q) begin
            mem_re  = 1'b1;
            rd_addr = ptr_inc[AW-1:0];
          end else begin
            state_d = ST_IDLE;
          end
        end else if (rd_col == pcol_q) begin
          ptr_d       = ptr_inc;
          out_valid_d = 1'b1;
          col_d       = pcol_q;
          prod_d      = mul;
          end_d       = 1'b0;
          rovf_d      = 1'b0;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    pcol_q <= pcol_d;
    pval_q <= pval_d;
    col_q  <= col_d;
    prod_q <= prod_d;
    end_q  <= end_d;
    rovf_q <= rovf_d;
  end

  // Row buffer: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= {cmd_i.col, cmd_i.val};
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign empty           = !out_valid_q;
  assign result_column_o = col_q;
  assign product_o       = prod_q;
  assign row_end_o       = end_q;
  assign row_overflow_o  = rovf_q;

`ifndef SYNTHESIS
  a_ptr_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= cnt_q)
    else $error("merge pointer beyond buffer fill");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ROW_NNZ_MAX))
    else $error("row buffer fill beyond capacity");
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !out_valid_q)
    else $error("probe in flight while result slot occupied");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> (out_valid_q && $stable(prod_q) && $stable(col_q)))
    else $error("waiting result overwritten");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && end_d && !out_valid_q) |=> (cnt_q == '0 && !ovf_q))
    else $error("end of row did not clear buffer");
`endif

endmodule

`default_nettype wire

// ===== tb/srmim_checker.sv =====
// Checker for the sparse row merge intersect multiply block: watches both queue ports,
// predicts each result from the accepted items and compares it field by field.
// Depends on srmim_pkg for operation codes and field widths.
`default_nettype none

module srmim_checker #(
  parameter int unsigned     ROW_CAP   = 256,
  parameter longint unsigned COL_LIMIT = 64'd65536
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic                           full_i,
  input  wire logic [1:0]                     op_i,
  input  wire logic [srmim_pkg::COL_W-1:0]    col_i,
  input  wire logic [srmim_pkg::VAL_W-1:0]    val_i,
  input  wire logic                           empty_i,
  input  wire logic                           pop_i,
  input  wire logic [srmim_pkg::COL_W-1:0]    res_col_i,
  input  wire logic [srmim_pkg::PROD_W-1:0]   prod_i,
  input  wire logic                           row_end_i,
  input  wire logic                           row_ovf_i,
  output int unsigned                         mismatch_count_o,
  output int unsigned                         outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [srmim_pkg::COL_W-1:0]  col;
    logic [srmim_pkg::PROD_W-1:0] prod;
    logic                         row_end;
    logic                         ovf;
  } merge_out_t;

  logic [srmim_pkg::COL_W-1:0] row_cols [ROW_CAP];
  logic [srmim_pkg::VAL_W-1:0] row_vals [ROW_CAP];
  int unsigned      fill;
  int unsigned      rd_ptr;
  logic             dropped;
  merge_out_t       expected_q [$];
  int unsigned      mismatches = 0;

  task automatic predict(input logic [1:0] op, input logic [srmim_pkg::COL_W-1:0] col,
                         input logic [srmim_pkg::VAL_W-1:0] val);
    merge_out_t hit;
    logic [srmim_pkg::VAL_W-1:0] a_val;
    if (op == srmim_pkg::OP_END) begin
      hit.col = '0;
      hit.prod = '0;
      hit.row_end = 1'b1;
      hit.ovf = dropped;
      expected_q.push_back(hit);
      fill = 0;
      rd_ptr = 0;
      dropped = 1'b0;
    end else if (op == srmim_pkg::OP_LOAD && col < COL_LIMIT) begin
      if (fill < ROW_CAP) begin
        row_cols[fill] = col;
        row_vals[fill] = val;
        fill++;
      end else begin
        dropped = 1'b1;
      end
    end else if (op == srmim_pkg::OP_PROBE && col < COL_LIMIT) begin
      while (rd_ptr < fill && row_cols[rd_ptr] < col) rd_ptr++;
      if (rd_ptr < fill && row_cols[rd_ptr] == col) begin
        a_val = row_vals[rd_ptr];
        hit.col = col;
        hit.prod = $signed({{32{a_val[31]}}, a_val}) * $signed({{32{val[31]}}, val});
        hit.row_end = 1'b0;
        hit.ovf = 1'b0;
        expected_q.push_back(hit);
        rd_ptr++;
      end
    end
  endtask

  task automatic check_result();
    merge_out_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result col=%0d prod=%0d end=%b ovf=%b", $realtime,
                 res_col_i, $signed(prod_i), row_end_i, row_ovf_i);
    end else begin
      want = expected_q.pop_front();
      if (res_col_i !== want.col || prod_i !== want.prod ||
          row_end_i !== want.row_end || row_ovf_i !== want.ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch expected col=%0d prod=%0d end=%b ovf=%b,",
                   $realtime, want.col, $signed(want.prod), want.row_end, want.ovf,
                   " got col=%0d prod=%0d end=%b ovf=%b",
                   res_col_i, $signed(prod_i), row_end_i, row_ovf_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill = 0;
      rd_ptr = 0;
      dropped = 1'b0;
      expected_q.delete();
      outstanding_o <= 0;
    end else begin
      if (pop_i && !empty_i) check_result();
      if (push_i && !full_i) predict(op_i, col_i, val_i);
      outstanding_o <= expected_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_sparse_row_merge_intersect_multiply.sv =====
// Testbench top for sparse_row_merge_intersect_multiply: drives rows of A loads,
// B probes and end-of-row items, stalls the result side, and reports the verdict.
// Depends on srmim_pkg, srmim_checker and the block itself.
`default_nettype none

module tb_sparse_row_merge_intersect_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned     ROW_CAP        = 256;
  localparam longint unsigned COL_LIMIT      = 64'd65536;
  localparam logic [1:0]      OP_UNUSED      = 2'd3;
  localparam int              RANDOM_ITEMS   = 700;
  localparam int              CALM_AFTER     = 600;
  localparam int              DRAIN_CYCLES   = 20;
  localparam int              WATCHDOG_LIMIT = 5000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         push = 1'b0;
  logic                         full;
  logic [1:0]                   operation_i = srmim_pkg::OP_LOAD;
  logic [srmim_pkg::COL_W-1:0]  element_column_i = '0;
  logic [srmim_pkg::VAL_W-1:0]  element_value_i = '0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic [srmim_pkg::COL_W-1:0]  result_column_o;
  logic [srmim_pkg::PROD_W-1:0] product_o;
  logic                         row_end_o;
  logic                         row_overflow_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int          items_sent = 0;
  int          push_gap_pct = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  always #5 clk_i = ~clk_i;

  sparse_row_merge_intersect_multiply #(
    .ROW_NNZ_MAX (ROW_CAP),
    .COLS        (COL_LIMIT)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .operation_i      (operation_i),
    .element_column_i (element_column_i),
    .element_value_i  (element_value_i),
    .empty            (empty),
    .pop              (pop),
    .result_column_o  (result_column_o),
    .product_o        (product_o),
    .row_end_o        (row_end_o),
    .row_overflow_o   (row_overflow_o)
  );

  srmim_checker #(
    .ROW_CAP   (ROW_CAP),
    .COL_LIMIT (COL_LIMIT)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .op_i             (operation_i),
    .col_i            (element_column_i),
    .val_i            (element_value_i),
    .empty_i          (empty),
    .pop_i            (pop),
    .res_col_i        (result_column_o),
    .prod_i           (product_o),
    .row_end_i        (row_end_o),
    .row_ovf_i        (row_overflow_o),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  // Stall rate for a stretch of traffic: none, light or heavy.
  function automatic int pick_gap();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 40;
    endcase
  endfunction

  // Favor the signed extremes so the product corners show up often.
  function automatic logic [srmim_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Drop push for a random burst before the next item, unless traffic is calm.
  task automatic lull();
    if (!calm && push_gap_pct != 0 && $urandom_range(0, 99) < push_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Present one item and hold it until the block takes it.
  task automatic send_item(input logic [1:0] op, input logic [srmim_pkg::COL_W-1:0] col,
                           input logic [srmim_pkg::VAL_W-1:0] val);
    lull();
    push <= 1'b1;
    operation_i <= op;
    element_column_i <= col;
    element_value_i <= val;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // One row: ascending A loads, then B probes that mostly hit A columns, then the
  // end item. Long rows can overrun the buffer and force long skip chains. Broken
  // rows swap probes out of order, mix in unused ops, load A after probes start
  // and sometimes omit the end so the next row piles onto this buffer.
  task automatic run_row(input bit long_row);
    logic [srmim_pkg::COL_W-1:0] a_cols [$];
    logic [srmim_pkg::COL_W-1:0] b_cols [$];
    logic [srmim_pkg::COL_W-1:0] tmp;
    int  n_a;
    int  step_max;
    int  c;
    int  lastb;
    int  k;
    int  j;
    bit  broken;
    n_a = long_row ? $urandom_range(250, 262) : $urandom_range(0, 12);
    step_max = long_row ? 200 : $urandom_range(1, 6000);
    c = $urandom_range(0, long_row ? 2000 : 65535);
    for (k = 0; k < n_a; k++) begin
      if (k > 0) c += ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, step_max);
      if (c > 65535) c = 65535;
      a_cols.push_back(16'(c));
    end

    lastb = 0;
    foreach (a_cols[k]) begin
      j = $urandom_range(0, 9);
      if (long_row ? (j == 0) : (j < 6)) begin
        b_cols.push_back(a_cols[k]);
        lastb = a_cols[k];
      end else if (!long_row && j < 8) begin
        lastb = $urandom_range(lastb, a_cols[k]);
        b_cols.push_back(16'(lastb));
      end
    end
    if ($urandom_range(0, 2) == 0) b_cols.push_back(16'($urandom_range(lastb, 65535)));
    if (n_a == 0)
      repeat ($urandom_range(0, 2)) b_cols.push_back(16'($urandom_range(0, 65535)));

    broken = ($urandom_range(0, 7) == 0);
    if (broken && b_cols.size() >= 2) begin
      k = $urandom_range(0, b_cols.size() - 1);
      j = $urandom_range(0, b_cols.size() - 1);
      tmp = b_cols[k];
      b_cols[k] = b_cols[j];
      b_cols[j] = tmp;
    end

    push_gap_pct = pick_gap();
    foreach (a_cols[k]) begin
      send_item(srmim_pkg::OP_LOAD, a_cols[k], rand_value());
      if ((broken && $urandom_range(0, 5) == 0) || $urandom_range(0, 29) == 0)
        send_item(OP_UNUSED, 16'($urandom()), $urandom());
    end
    foreach (b_cols[k]) begin
      if (broken && k == b_cols.size() / 2)
        send_item(srmim_pkg::OP_LOAD, 16'($urandom_range(0, 65535)), rand_value());
      send_item(srmim_pkg::OP_PROBE, b_cols[k], rand_value());
    end
    if (!(broken && $urandom_range(0, 3) == 0))
      send_item(srmim_pkg::OP_END, 16'($urandom()), $urandom());
  endtask

  // Result side: pop high most of the time, with bursts of stalls whose rate
  // is picked anew for each window; no stalls once traffic is calm.
  initial begin : pop_side
    int hold_left;
    int pop_gap_pct;
    int window;
    hold_left = 0;
    pop_gap_pct = 0;
    window = 0;
    forever begin
      @(posedge clk_i);
      if (window == 0) begin
        window = 100;
        pop_gap_pct = pick_gap();
      end
      window--;
      if (hold_left == 0 && !calm && pop_gap_pct != 0 &&
          $urandom_range(0, 99) < pop_gap_pct)
        hold_left = $urandom_range(1, 14);
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // End the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int row_idx;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: value extremes at column extremes, an unused op, a miss.
    push_gap_pct = 30;
    send_item(srmim_pkg::OP_LOAD, 16'd0, 32'h8000_0000);
    send_item(srmim_pkg::OP_LOAD, 16'd5, 32'h7FFF_FFFF);
    send_item(srmim_pkg::OP_LOAD, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(srmim_pkg::OP_PROBE, 16'd0, 32'h8000_0000);
    send_item(srmim_pkg::OP_PROBE, 16'd3, 32'd1);
    send_item(srmim_pkg::OP_PROBE, 16'd5, 32'h8000_0000);
    send_item(srmim_pkg::OP_PROBE, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(srmim_pkg::OP_END, 16'hFFFF, 32'hFFFF_FFFF);
    // Skip past two entries with no match, probe behind the pointer, append A
    // after probes began, and probe a column whose entry was already used.
    send_item(srmim_pkg::OP_LOAD, 16'd10, 32'd1);
    send_item(srmim_pkg::OP_LOAD, 16'd20, -32'sd2);
    send_item(srmim_pkg::OP_LOAD, 16'd30, 32'd3);
    send_item(srmim_pkg::OP_PROBE, 16'd25, 32'd5);
    send_item(srmim_pkg::OP_PROBE, 16'd10, 32'd7);
    send_item(srmim_pkg::OP_LOAD, 16'd40, 32'd9);
    send_item(srmim_pkg::OP_PROBE, 16'd30, 32'd4);
    send_item(srmim_pkg::OP_PROBE, 16'd40, 32'hFFFF_FFFF);
    send_item(srmim_pkg::OP_PROBE, 16'd40, 32'd2);
    send_item(srmim_pkg::OP_END, 16'd0, 32'd0);
    // Repeated A column matched by repeated probes, then an empty row.
    send_item(srmim_pkg::OP_LOAD, 16'd50, 32'd2);
    send_item(srmim_pkg::OP_LOAD, 16'd50, 32'd3);
    send_item(srmim_pkg::OP_PROBE, 16'd50, 32'd1);
    send_item(srmim_pkg::OP_PROBE, 16'd50, 32'd1);
    send_item(srmim_pkg::OP_END, 16'd0, 32'd0);
    send_item(srmim_pkg::OP_END, 16'd0, 32'd0);

    // Random rows; the second one is always a long row that may overrun the row buffer.
    items_sent = 0;
    row_idx = 0;
    while (items_sent < RANDOM_ITEMS) begin
      run_row(row_idx == 1 || (items_sent < 300 && $urandom_range(0, 19) == 0));
      row_idx++;
      calm = (items_sent >= CALM_AFTER);
    end
    push <= 1'b0;

    // Drain every expected result, then give stray results time to show up.
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
